@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/pal_pkg.sv @@
// Package for the positional array list: codes, types and command/status bundles.
`default_nettype none

package pal_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int WORD_W       = 32;
	localparam int LEN_W        = 8;
	localparam int POS_W        = 8;

	localparam logic signed [WORD_W-1:0] READ_FAIL = -32'sd1;

	typedef enum logic [1:0] {
		REQ_GET    = 2'd0,
		REQ_SET    = 2'd1,
		REQ_INSERT = 2'd2,
		REQ_DELETE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_GET_RD,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PLACE,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic cursor_init;
		logic cursor_step;
		logic rd_get;
		logic rd_shift;
		logic wr_set;
		logic wr_shift;
		logic wr_place;
		logic emit;
	} pal_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_t kind;
		logic in_list;
		logic full;
		logic ins_ok;
		logic needs_move;
		logic last_move;
		logic out_free;
	} pal_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/positional_array_list.sv @@
// Top level of the positional array list: controller, datapath and port packing.
//
// Channel   Dir  Contents
// s_*       in   tuser = req_type[1:0]; tdata = position[7:0], new_value[39:8]
// m_*       out  tuser = status[1:0];   tdata = read_value[31:0], list_len[39:32]
//
// One request is worked at a time; the element memory has one write and one
// registered read port, and every word moved by insert or delete passes through
// a shift-read state and a shift-write state.
// A new request is accepted while the previous result still waits in the output
// register; its result waits until that one is taken. Reset clears the length.
`default_nettype none

module positional_array_list
	import pal_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // position[7:0], new_value[39:8]
	input  wire  [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], list_len[39:32]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

	pal_cmd_t                 cmd;
	pal_stat_t                stat;
	logic signed [WORD_W-1:0] read_value;
	status_t                  status;
	logic [LEN_W-1:0]         list_len;

	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pal_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (s_tuser),
		.position   (s_tdata[POS_W-1:0]),
		.new_value  (s_tdata[POS_W+WORD_W-1:POS_W]),
		.cmd        (cmd),
		.stat       (stat),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.read_value (read_value),
		.status     (status),
		.list_len   (list_len)
	);

	assign m_tdata = {list_len, read_value};
	assign m_tuser = status;

`include "assert_macros.svh"

	// Requests are worked one at a time.
	`ASSERT_CLK(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "request accepted while busy")
	// A full-list refusal reports a length equal to the capacity.
	`ASSERT_CLK(a_full_len, (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[39:32] == CAP_LEN), "full status with short list")
	// The reported length never goes beyond the capacity.
	`ASSERT_NEVER(a_len_cap, m_tvalid && (m_tdata[39:32] > CAP_LEN), "list length beyond capacity")

endmodule

`default_nettype wire

@@ rtl/core/pal_ctrl.sv @@
// Controller state machine of the positional array list.
`default_nettype none

module pal_ctrl
	import pal_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	output logic      req_ready,
	input  pal_stat_t stat,
	output pal_cmd_t  cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (stat.kind)
					REQ_GET:    state_nx = stat.in_list ? S_GET_RD : S_RESULT;
					REQ_SET:    state_nx = S_RESULT;
					REQ_INSERT: begin
						if (stat.full || !stat.ins_ok) begin
							state_nx = S_RESULT;
						end else begin
							state_nx = stat.needs_move ? S_SHIFT_RD : S_PLACE;
						end
					end
					REQ_DELETE: begin
						state_nx = (stat.in_list && stat.needs_move) ? S_SHIFT_RD : S_RESULT;
					end
					default: state_nx = S_RESULT;
				endcase
			end
			S_GET_RD:   state_nx = S_RESULT;
			S_SHIFT_RD: state_nx = S_SHIFT_WR;
			S_SHIFT_WR: begin
				if (stat.last_move) begin
					state_nx = (stat.kind == REQ_INSERT) ? S_PLACE : S_RESULT;
				end else begin
					state_nx = S_SHIFT_RD;
				end
			end
			S_PLACE:    state_nx = S_RESULT;
			S_RESULT: begin
				if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_DECIDE: begin
				cmd.cursor_init = 1'b1;
				cmd.wr_set      = (stat.kind == REQ_SET) && stat.in_list;
			end
			S_GET_RD:   cmd.rd_get = 1'b1;
			S_SHIFT_RD: cmd.rd_shift = 1'b1;
			S_SHIFT_WR: begin
				cmd.wr_shift    = 1'b1;
				cmd.cursor_step = !stat.last_move;
			end
			S_PLACE:    cmd.wr_place = 1'b1;
			S_RESULT:   cmd.emit = stat.out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/pal_dp.sv @@
// Datapath of the positional array list: element memory, length, cursor and result register.
`default_nettype none

module pal_dp
	import pal_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  [1:0]               req_type,
	input  wire  [POS_W-1:0]         position,
	input  wire  signed [WORD_W-1:0] new_value,
	input  pal_cmd_t                 cmd,
	output pal_stat_t                stat,
	output logic                     res_valid,
	input  wire                      res_ready,
	output logic signed [WORD_W-1:0] read_value,
	output status_t                  status,
	output logic [LEN_W-1:0]         list_len
);

	localparam int AW = $clog2(CAPACITY);
	localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

	logic [WORD_W-1:0] mem_q [CAPACITY];

	req_t              kind_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;
	logic [LEN_W-1:0]  len_q;
	logic [AW-1:0]     cursor_q;
	logic [WORD_W-1:0] rdata_q;

	logic              res_valid_q;
	logic [WORD_W-1:0] res_value_q;
	status_t           res_status_q;
	logic [LEN_W-1:0]  res_len_q;

	logic [LEN_W:0]    len_ext;
	logic [LEN_W:0]    pos_ext;
	logic [AW-1:0]     pos_addr;
	logic              is_ins;
	logic              in_list;
	logic              full;
	logic              ins_ok;
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;
	logic              rd_en;
	status_t           st_nx;
	logic [WORD_W-1:0] value_nx;
	logic [LEN_W-1:0]  len_nx;

	assign len_ext  = {1'b0, len_q};
	assign pos_ext  = {1'b0, pos_q};
	assign pos_addr = AW'(pos_q - POS_W'(1));
	assign is_ins   = (kind_q == REQ_INSERT);
	// Since the length never exceeds the capacity, a position within the length is in range.
	assign in_list  = (pos_q != '0) && (pos_q <= len_q);
	assign full     = (len_q >= CAP_LEN);
	assign ins_ok   = (pos_q != '0) && (pos_ext <= len_ext + (LEN_W+1)'(1));

	always_comb begin
		stat.kind     = kind_q;
		stat.in_list  = in_list;
		stat.full     = full;
		stat.ins_ok   = ins_ok;
		stat.out_free = !res_valid_q || res_ready;
		if (is_ins) begin
			// Insert at the end moves nothing.
			stat.needs_move = (pos_q <= len_q);
			stat.last_move  = (LEN_W'(cursor_q) == pos_q);
		end else begin
			stat.needs_move = (pos_q < len_q);
			stat.last_move  = ((LEN_W+1)'(cursor_q) + (LEN_W+1)'(2) == len_ext);
		end
	end

	// Request registers and cursor.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req_t'(req_type);
			pos_q  <= position;
			word_q <= new_value;
		end
		if (cmd.cursor_init) begin
			cursor_q <= is_ins ? AW'(len_q) : pos_addr;
		end else if (cmd.cursor_step) begin
			cursor_q <= is_ins ? cursor_q - AW'(1) : cursor_q + AW'(1);
		end
	end

	// Single write port and single registered read port.
	always_comb begin
		mem_we  = cmd.wr_set || cmd.wr_shift || cmd.wr_place;
		wr_addr = cmd.wr_shift ? cursor_q : pos_addr;
		wr_data = cmd.wr_shift ? rdata_q : word_q;
		rd_en   = cmd.rd_get || cmd.rd_shift;
		if (cmd.rd_shift) begin
			rd_addr = is_ins ? cursor_q - AW'(1) : cursor_q + AW'(1);
		end else begin
			rd_addr = pos_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// Result fields and the length after the request.
	always_comb begin
		value_nx = '0;
		len_nx   = len_q;
		st_nx    = ST_OK;
		unique case (kind_q)
			REQ_GET: begin
				if (in_list) begin
					value_nx = rdata_q;
				end else begin
					value_nx = READ_FAIL;
					st_nx    = ST_RANGE;
				end
			end
			REQ_SET: begin
				st_nx = in_list ? ST_OK : ST_RANGE;
			end
			REQ_INSERT: begin
				priority if (full) begin
					st_nx = ST_FULL;
				end else if (!ins_ok) begin
					st_nx = ST_RANGE;
				end else begin
					len_nx = len_q + LEN_W'(1);
				end
			end
			REQ_DELETE: begin
				if (in_list) begin
					len_nx = len_q - LEN_W'(1);
				end else begin
					st_nx = ST_RANGE;
				end
			end
			default: st_nx = ST_RANGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				len_q       <= len_nx;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_value_q  <= value_nx;
			res_status_q <= st_nx;
			res_len_q    <= len_nx;
		end
	end

	assign res_valid  = res_valid_q;
	assign read_value = res_value_q;
	assign status     = res_status_q;
	assign list_len   = res_len_q;

endmodule

`default_nettype wire

@@ dv/tb_positional_array_list.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the positional array list: directed and random requests with a list predictor.
module tb_positional_array_list;
	import pal_pkg::*;

	localparam int CAP     = CAPACITY_DEF;
	localparam int LATENCY = 4 + 2 * CAP;

	typedef struct {
		logic signed [WORD_W-1:0] rd;
		status_t                  st;
		logic [LEN_W-1:0]         len;
	} list_result_t;

	// Keeps its own copy of the list and the results that accepted requests should produce.
	class list_scoreboard;
		logic [WORD_W-1:0] words [CAP];
		int                length;
		list_result_t      pending_q [$];
		int                errors;

		function new();
			length = 0;
			errors = 0;
		endfunction

		function void note_request(req_t kind, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
			list_result_t r;
			int           p;
			bit           in_list;
			p       = int'(pos);
			in_list = (p >= 1) && (p <= length);
			r.rd    = '0;
			r.st    = ST_OK;
			case (kind)
				REQ_GET: begin
					if (in_list) begin
						r.rd = words[p-1];
					end else begin
						r.rd = READ_FAIL;
						r.st = ST_RANGE;
					end
				end
				REQ_SET: begin
					if (in_list) begin
						words[p-1] = word;
					end else begin
						r.st = ST_RANGE;
					end
				end
				REQ_INSERT: begin
					// A full list is reported before the position is looked at.
					if (length >= CAP) begin
						r.st = ST_FULL;
					end else if (p < 1 || p > length + 1) begin
						r.st = ST_RANGE;
					end else begin
						for (int k = length; k >= p; k--) begin
							words[k] = words[k-1];
						end
						words[p-1] = word;
						length++;
					end
				end
				default: begin
					if (in_list) begin
						for (int k = p - 1; k < length - 1; k++) begin
							words[k] = words[k+1];
						end
						length--;
					end else begin
						r.st = ST_RANGE;
					end
				end
			endcase
			r.len = LEN_W'(length);
			pending_q.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 40) begin
				$display("mismatch at %0t: %s", $time, msg);
			end
			errors++;
		endtask

		task check_result(logic [WORD_W-1:0] rd, logic [1:0] st, logic [LEN_W-1:0] len);
			list_result_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("result with no request pending: rd=%h st=%0d len=%0d",
					rd, st, len));
				return;
			end
			want = pending_q.pop_front();
			if (rd !== want.rd) begin
				report($sformatf("read_value %h, expected %h", rd, want.rd));
			end
			if (st !== want.st) begin
				report($sformatf("status %0d, expected %0d", st, want.st));
			end
			if (len !== want.len) begin
				report($sformatf("list_len %0d, expected %0d", len, want.len));
			end
		endtask
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [39:0]           s_tdata  = '0;
	logic [1:0]            s_tuser  = '0;
	logic                  m_tready = 1'b0;
	wire                   s_tready;
	wire                   m_tvalid;
	wire  [39:0]           m_tdata;
	wire  [1:0]            m_tuser;

	int                    snd_idle = 0;
	int                    rcv_idle = 0;
	bit                    growing  = 1'b1;
	int                    ends_hit = 0;
	list_scoreboard        sb       = new();

	positional_array_list i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle);
	end

	// Outputs are sampled at the falling edge, where they are stable before the taking edge.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata[31:0], m_tuser, m_tdata[39:32]);
		end
	end

	// Entered and left at a rising edge; the request is noted once it is sure to be taken.
	task automatic send_request(input req_t kind, input logic [POS_W-1:0] pos,
		input logic [WORD_W-1:0] word);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {word, pos};
		do @(negedge clk); while (!s_tready);
		sb.note_request(kind, pos, word);
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	// Fills the list toward full and empties it again, with some malformed positions mixed in.
	task automatic run_phase(input int count);
		req_t              kind;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
		int                r;
		int                top;
		for (int i = 0; i < count; i++) begin
			if (growing && sb.length == CAP) begin
				ends_hit++;
			end else if (!growing && sb.length == 0) begin
				ends_hit++;
			end
			if (ends_hit >= 4) begin
				growing  = !growing;
				ends_hit = 0;
			end
			r = $urandom_range(99);
			if (r < 55) begin
				kind = growing ? REQ_INSERT : REQ_DELETE;
			end else if (r < 65) begin
				kind = growing ? REQ_DELETE : REQ_INSERT;
			end else if (r < 82) begin
				kind = REQ_GET;
			end else begin
				kind = REQ_SET;
			end
			top = (kind == REQ_INSERT) ? sb.length + 1 : sb.length;
			r   = $urandom_range(99);
			if (r < 80 && top >= 1) begin
				pos = POS_W'($urandom_range(top, 1));
			end else if (r < 88) begin
				pos = '0;
			end else if (r < 94 && top < 255) begin
				pos = POS_W'(top + 1);
			end else begin
				pos = POS_W'($urandom_range(255, 0));
			end
			r = $urandom_range(99);
			if (r < 8) begin
				word = 32'h7FFF_FFFF;
			end else if (r < 16) begin
				word = 32'h8000_0000;
			end else begin
				word = $urandom();
			end
			send_request(kind, pos, word);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests against an empty list, then a small list built at the front, back and middle.
		send_request(REQ_GET, 8'd1, 32'h1234_5678);
		send_request(REQ_SET, 8'd1, 32'hDEAD_BEEF);
		send_request(REQ_DELETE, 8'd0, 32'h0);
		send_request(REQ_INSERT, 8'd0, 32'h1111_1111);
		send_request(REQ_INSERT, 8'd2, 32'h2222_2222);
		send_request(REQ_INSERT, 8'd1, 32'h7FFF_FFFF);
		send_request(REQ_INSERT, 8'd2, 32'h8000_0000);
		send_request(REQ_INSERT, 8'd1, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 8'd2, 32'h0000_0000);
		for (int p = 1; p <= 5; p++) begin
			send_request(REQ_GET, p[POS_W-1:0], 32'h0);
		end
		send_request(REQ_GET, 8'd0, 32'h0);
		send_request(REQ_SET, 8'd4, 32'h5555_5555);
		send_request(REQ_SET, 8'd255, 32'hAAAA_AAAA);
		send_request(REQ_GET, 8'd4, 32'h0);
		send_request(REQ_DELETE, 8'd255, 32'h0);
		send_request(REQ_DELETE, 8'd5, 32'h0);
		send_request(REQ_DELETE, 8'd4, 32'h0);
		send_request(REQ_DELETE, 8'd1, 32'h0);
		send_request(REQ_GET, 8'd1, 32'h0);
		send_request(REQ_INSERT, 8'd4, 32'h3333_3333);
		send_request(REQ_GET, 8'd255, 32'h0);
		drain();

		snd_idle = 26;
		rcv_idle = 76;
		run_phase(320);
		drain();
		snd_idle = 76;
		rcv_idle = 26;
		run_phase(320);
		drain();
		snd_idle = 0;
		rcv_idle = 0;
		run_phase(310);

		drain();
		repeat (LATENCY) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pal_pkg.sv
rtl/core/pal_ctrl.sv
rtl/core/pal_dp.sv
rtl/core/positional_array_list.sv
dv/tb_positional_array_list.sv
